>>> design/srlpf_pkg.sv
// Shared constants and types of the shift-register LED PWM framer.
`timescale 1ns / 1ps
`default_nettype none
package srlpf_pkg;

	localparam int LED_COUNT   = 16;
	localparam int SHIFT_REGS  = 8;

	localparam int CMD_W       = 2;
	localparam int LED_INDEX_W = 4;
	localparam int LEVEL_W     = 8;
	localparam int COLOR_W     = 3 * LEVEL_W;
	localparam int BYTE_W      = 8;

	localparam int LED_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int CNT_W       = $clog2(LED_COUNT + 1);
	localparam int IDX_CMP_W   = (CNT_W > LED_INDEX_W) ? CNT_W : LED_INDEX_W;
	localparam int TOTAL_BITS  = BYTE_W * SHIFT_REGS;
	localparam int FR_W        = $clog2(TOTAL_BITS);
	localparam int CH_RAW_W    = $clog2(3 * LED_COUNT);
	localparam int CH_W        = (CH_RAW_W > FR_W + 1) ? CH_RAW_W : FR_W + 1;
	localparam int SWEEP_MAX   = (TOTAL_BITS + 2) / 3;
	localparam int SWEEP_N     = (LED_COUNT < SWEEP_MAX) ? LED_COUNT : SWEEP_MAX;
	localparam int SW_W        = $clog2(SWEEP_N + 1);
	localparam int BCNT_W      = (SHIFT_REGS > 1) ? $clog2(SHIFT_REGS) : 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_CLEAR = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

>>> design/srlpf_ifs.sv
// Valid/ready channel interfaces for command beats and frame byte beats.
`timescale 1ns / 1ps
`default_nettype none
interface srlpf_req_if
	import srlpf_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [LED_INDEX_W-1:0] led_index;
	logic [LEVEL_W-1:0]     red_level;
	logic [LEVEL_W-1:0]     green_level;
	logic [LEVEL_W-1:0]     blue_level;

	modport source (output valid, command, led_index, red_level, green_level, blue_level,
		input ready);
	modport sink (input valid, command, led_index, red_level, green_level, blue_level,
		output ready);
endinterface

interface srlpf_frame_if
	import srlpf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink (input valid, frame_byte, last_byte, output ready);
endinterface
`default_nettype wire

>>> design/shift_register_led_pwm_framer_core.sv
// Top level of the shift-register LED PWM framer.
//
// Command beats arrive on req (valid/ready). A color write is written to
// the color RAM and gives no output. A frame command sweeps the LED color
// RAM, one LED per cycle over min(LED_COUNT, ceil(8*SHIFT_REGS/3)) LEDs,
// sets the channel bits of a frame register, advances the PWM slice, then
// sends SHIFT_REGS byte beats on frame, the last one flagged by last_byte.
// An all-off command clears the color valid bits and sends a zero frame.
// One command is in work at a time: req.ready is high only when no frame is
// pending. The RAM read port, one LED a cycle, sets the sweep length. A
// receiver stall holds the current byte and the block. reverse_order is
// written through cfg_we/cfg_wdata; the user must write it only while idle,
// which the block does not enforce. Reset clears all colors to zero (per-LED
// valid bits), the slice to zero and sets reverse_order.
`timescale 1ns / 1ps
`default_nettype none
module shift_register_led_pwm_framer_core
	import srlpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	srlpf_req_if.sink      req,
	srlpf_frame_if.source  frame
);

	state_t                  state_q, state_d;
	logic                    rev_q;
	logic [LEVEL_W-1:0]      slice_q;
	logic [LED_COUNT-1:0]    vld_q;
	logic [SW_W-1:0]         issue_q;
	logic [BCNT_W-1:0]       bcnt_q;
	logic [TOTAL_BITS-1:0]   frame_q;
	logic                    rd_s1;
	logic                    vld_s1;
	logic [LED_W-1:0]        idx_s1;

	logic                    accept;
	logic                    wr_en;
	logic                    rd_en;
	logic                    pop;
	logic                    last;
	logic                    sweep_done;
	logic [LED_W-1:0]        rd_addr;
	logic [COLOR_W-1:0]      rd_data;
	logic [COLOR_W-1:0]      color;
	logic [TOTAL_BITS-1:0]   frame_set;
	logic [BYTE_W-1:0]       byte_norm;
	command_t                cmd;

	assign cmd        = command_t'(req.command);
	assign accept     = req.valid && req.ready;
	assign pop        = frame.valid && frame.ready;
	assign last       = (bcnt_q == BCNT_W'(SHIFT_REGS - 1));
	assign rd_addr    = LED_W'(issue_q);
	assign rd_en      = (state_q == ST_SWEEP) && (issue_q < SW_W'(SWEEP_N));
	assign sweep_done = (state_q == ST_SWEEP) && !rd_en && !rd_s1;
	assign wr_en      = accept && (cmd == CMD_WRITE)
		&& (IDX_CMP_W'(req.led_index) < IDX_CMP_W'(LED_COUNT));

	srlpf_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(LED_COUNT)
	) u_color_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (LED_W'(req.led_index)),
		.wdata ({req.red_level, req.green_level, req.blue_level}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		frame.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (cmd)
						CMD_FRAME: state_d = ST_SWEEP;
						CMD_CLEAR: state_d = ST_EMIT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				frame.valid = 1'b1;
				if (pop && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q   <= 1'b1;
			slice_q <= '0;
			vld_q   <= '0;
			issue_q <= '0;
			bcnt_q  <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (cfg_we) begin
				rev_q <= cfg_wdata;
			end
			if (wr_en) begin
				vld_q[LED_W'(req.led_index)] <= 1'b1;
			end
			if (accept && cmd == CMD_CLEAR) begin
				vld_q <= '0;
			end
			if (accept) begin
				issue_q <= '0;
				bcnt_q  <= '0;
			end
			if (rd_en) begin
				issue_q <= issue_q + SW_W'(1);
			end
			if (sweep_done) begin
				slice_q <= slice_q + LEVEL_W'(1);
			end
			if (pop) begin
				bcnt_q <= bcnt_q + BCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			vld_s1 <= vld_q[rd_addr];
			idx_s1 <= rd_addr;
		end
		if (accept) begin
			frame_q <= '0;
		end else if (rd_s1) begin
			frame_q <= frame_q | frame_set;
		end else if (pop) begin
			if (rev_q) begin
				frame_q <= frame_q << BYTE_W;
			end else begin
				frame_q <= frame_q >> BYTE_W;
			end
		end
	end

	assign color = vld_s1 ? rd_data : '0;

	always_comb begin
		logic [CH_W-1:0] base;
		logic [CH_W-1:0] ch;
		logic            on;
		frame_set = '0;
		base      = CH_W'(idx_s1) * CH_W'(3);
		for (int k = 0; k < 3; k++) begin
			ch = base + CH_W'(k);
			on = color[k*LEVEL_W +: LEVEL_W] > slice_q;
			if (on && (ch < CH_W'(TOTAL_BITS))) begin
				frame_set[ch[FR_W-1:0]] = 1'b1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < BYTE_W; j++) begin
			byte_norm[BYTE_W-1-j] = frame_q[j];
		end
	end

	assign frame.frame_byte = rev_q ? frame_q[TOTAL_BITS-1 -: BYTE_W] : byte_norm;
	assign frame.last_byte  = last;

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> !req.ready)
		else $error("command beat accepted while frame pending");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && frame.last_byte) |=> !frame.valid)
		else $error("frame continues past last byte");

	a_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_SWEEP))
		else $error("color read returned outside sweep");

	a_slice_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(slice_q != $past(slice_q)) |-> ($past(state_q) == ST_SWEEP && state_q == ST_EMIT))
		else $error("slice changed outside frame build");

endmodule
`default_nettype wire

>>> design/srlpf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module srlpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> verif/shift_register_led_pwm_framer_core_tb.sv
// Testbench for the LED PWM framer: directed and random command beats checked byte by byte against a PWM predictor.
`timescale 1ns / 1ps
module shift_register_led_pwm_framer_core_tb;
	import srlpf_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int IDLE_PCT      = 9;
	localparam int RANDOM_ITEMS  = 280;
	localparam int WRAP_FRAMES   = 260;
	localparam int CHUNK_ITEMS   = 70;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_CYCLES  = 40;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PRINT_LIMIT   = 40;
	localparam longint TIMEOUT_NS = 5000000;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]       command;
		logic [LED_INDEX_W-1:0] led_index;
		logic [LEVEL_W-1:0]     red_level;
		logic [LEVEL_W-1:0]     green_level;
		logic [LEVEL_W-1:0]     blue_level;
	} led_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_byte;
	} frame_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	srlpf_req_if   req_ch();
	srlpf_frame_if frame_ch();

	shift_register_led_pwm_framer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.frame     (frame_ch)
	);

	led_cmd_t    pending_cmds[$];
	frame_beat_t expected_beats[$];
	led_cmd_t    next_cmd;
	frame_beat_t got_beat;

	logic [COLOR_W-1:0] led_color_model [LED_COUNT];
	logic [LEVEL_W-1:0] slice_model;
	logic               reverse_model;

	int mismatch_count;
	int cmds_queued;
	int frames_queued;
	bit calm;
	bit hold_armed;
	logic sink_hold;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("shift_register_led_pwm_framer_core test failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
		input logic [BYTE_W-1:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t MISMATCH %s: got %02h expected %02h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic void predict_led_command(input led_cmd_t cmd);
		logic [BYTE_W-1:0]  frame_bytes [SHIFT_REGS];
		logic [LEVEL_W-1:0] level;
		int chan;
		int pos;
		for (int i = 0; i < SHIFT_REGS; i++)
			frame_bytes[i] = '0;
		case (cmd.command)
			CMD_WRITE: begin
				if (int'(cmd.led_index) < LED_COUNT)
					led_color_model[cmd.led_index] = {cmd.red_level, cmd.green_level,
						cmd.blue_level};
				return;
			end
			CMD_FRAME: begin
				for (int led = 0; led < LED_COUNT; led++) begin
					for (int ch = 0; ch < 3; ch++) begin
						level = led_color_model[led][ch*LEVEL_W +: LEVEL_W];
						chan  = led * 3 + ch;
						if (level > slice_model && chan < TOTAL_BITS) begin
							pos = reverse_model ? TOTAL_BITS - 1 - chan : chan;
							frame_bytes[pos / 8][7 - (pos % 8)] = 1'b1;
						end
					end
				end
				slice_model = slice_model + 1'b1;
			end
			CMD_CLEAR: begin
				for (int led = 0; led < LED_COUNT; led++)
					led_color_model[led] = '0;
			end
			default: return;
		endcase
		for (int i = 0; i < SHIFT_REGS; i++)
			expected_beats.push_back({frame_bytes[i], i == SHIFT_REGS - 1});
	endfunction

	// command source: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.command     <= '0;
			req_ch.led_index   <= '0;
			req_ch.red_level   <= '0;
			req_ch.green_level <= '0;
			req_ch.blue_level  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_led_command({req_ch.command, req_ch.led_index, req_ch.red_level,
					req_ch.green_level, req_ch.blue_level});
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_cmd = pending_cmds.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.command     <= next_cmd.command;
					req_ch.led_index   <= next_cmd.led_index;
					req_ch.red_level   <= next_cmd.red_level;
					req_ch.green_level <= next_cmd.green_level;
					req_ch.blue_level  <= next_cmd.blue_level;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// frame sink: compare each byte beat, then decide on stalling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected frame beat", frame_ch.frame_byte, '0);
				end else begin
					got_beat = expected_beats.pop_front();
					if (frame_ch.frame_byte !== got_beat.frame_byte)
						report_mismatch("frame_byte", frame_ch.frame_byte, got_beat.frame_byte);
					if (frame_ch.last_byte !== got_beat.last_byte)
						report_mismatch("last_byte", BYTE_W'(frame_ch.last_byte),
							BYTE_W'(got_beat.last_byte));
				end
			end
			frame_ch.ready <= !sink_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// hold off the sink for a long stretch so the block backs up
	initial begin
		sink_hold = 1'b0;
		wait (hold_armed);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [LED_INDEX_W-1:0] idx,
		input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] green,
		input logic [LEVEL_W-1:0] blue);
		pending_cmds.push_back({cmd, idx, red, green, blue});
		cmds_queued++;
		if (cmd == CMD_FRAME)
			frames_queued++;
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		if (roll < 20)
			return '1;
		return LEVEL_W'($urandom_range(0, 255));
	endfunction

	// zero to two color writes followed by a run of frames, sometimes a clear or a spare code
	task automatic add_pwm_burst();
		int n_writes;
		int n_frames;
		int roll;
		n_writes = $urandom_range(0, 2);
		n_frames = $urandom_range(4, 10);
		repeat (n_writes)
			push_cmd(CMD_WRITE, LED_INDEX_W'($urandom_range(0, 15)), pick_level(), pick_level(),
				pick_level());
		repeat (n_frames)
			push_cmd(CMD_FRAME, LED_INDEX_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
				LEVEL_W'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 6)
			push_cmd(CMD_CLEAR, LED_INDEX_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
				LEVEL_W'($urandom));
		else if (roll < 12)
			push_cmd(CMD_SPARE, LED_INDEX_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
				LEVEL_W'($urandom));
	endtask

	task automatic wait_quiet();
		int guard;
		guard = 0;
		while ((pending_cmds.size() != 0 || req_ch.valid || expected_beats.size() != 0)
			&& guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reverse(input logic value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reverse_model = value;
	endtask

	function automatic bit more_random(input int first_random);
		return cmds_queued - first_random < RANDOM_ITEMS || frames_queued < WRAP_FRAMES;
	endfunction

	initial begin
		int first_random;
		int chunk_start;
		int chunk;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.command     = '0;
		req_ch.led_index   = '0;
		req_ch.red_level   = '0;
		req_ch.green_level = '0;
		req_ch.blue_level  = '0;
		frame_ch.ready     = 1'b0;
		mismatch_count     = 0;
		cmds_queued        = 0;
		frames_queued      = 0;
		calm               = 1'b0;
		hold_armed         = 1'b0;
		for (int led = 0; led < LED_COUNT; led++)
			led_color_model[led] = '0;
		slice_model   = '0;
		reverse_model = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset order, extremes, overwrite, spare code, clear
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_WRITE, 4'h0, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(CMD_WRITE, 4'hF, 8'h80, 8'h01, 8'hFE);
		push_cmd(CMD_WRITE, 4'h5, 8'h55, 8'hCC, 8'hF0);
		push_cmd(CMD_WRITE, 4'hA, 8'h01, 8'h02, 8'h00);
		push_cmd(CMD_FRAME, 4'hF, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_SPARE, 4'hF, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(CMD_WRITE, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_WRITE, 4'h3, 8'h03, 8'h04, 8'h05);
		push_cmd(CMD_CLEAR, 4'hF, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_WRITE, 4'hF, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(CMD_WRITE, 4'h0, 8'hFF, 8'h00, 8'hFF);
		push_cmd(CMD_WRITE, 4'h7, 8'hAA, 8'h55, 8'hCC);
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		push_cmd(CMD_FRAME, 4'h0, 8'h00, 8'h00, 8'h00);
		wait_quiet();

		first_random = cmds_queued;
		chunk = 0;
		while (more_random(first_random)) begin
			write_reverse(chunk % 2 != 0);
			calm = (chunk == 1);
			if (chunk == 2)
				hold_armed = 1'b1;
			@(negedge clk);
			chunk_start = cmds_queued;
			while (cmds_queued - chunk_start < CHUNK_ITEMS && more_random(first_random))
				add_pwm_burst();
			wait_quiet();
			chunk++;
		end

		if (expected_beats.size() != 0)
			report_mismatch("frame beats never delivered", '0, BYTE_W'(expected_beats.size()));
		if (mismatch_count == 0)
			$display("shift_register_led_pwm_framer_core test passed");
		else
			$display("shift_register_led_pwm_framer_core test failed");
		$finish;
	end

endmodule
